[sv/relo_pkg.sv]
// Shared types, constants and microcode table for the ring entry offset locator.
`timescale 1ns / 1ps

package relo_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int TAG_W     = 32;
	localparam int SIZE_W    = 16;
	localparam int OFFSET_W  = 20;
	localparam int SLOT_F_W  = 4;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_FIND = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [TAG_W-1:0]    entry_tag;
		logic [SIZE_W-1:0]   entry_size;
		logic [OFFSET_W-1:0] byte_offset;
	} in_item_t;

	typedef struct packed {
		logic                hit;
		logic [SLOT_F_W-1:0] slot;
		logic [TAG_W-1:0]    found_tag;
		logic [SIZE_W-1:0]   found_size;
		logic [SIZE_W-1:0]   offset_within;
	} out_item_t;

	// microcode step addresses
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN
	} step_t;

	// jump conditions
	typedef enum logic [1:0] {
		JC_DISPATCH,
		JC_POST,
		JC_SCAN
	} jcond_t;

	typedef struct packed {
		logic   accept;
		logic   ring_wr;
		logic   scan;
		jcond_t jc;
		step_t  tgt;
	} ctrl_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t cw;
		cw = '{accept: 1'b0, ring_wr: 1'b0, scan: 1'b0, jc: JC_DISPATCH, tgt: ST_IDLE};
		unique case (s)
			ST_IDLE: begin
				cw.accept = 1'b1;
				cw.jc     = JC_DISPATCH;
			end
			ST_ADD: begin
				cw.ring_wr = 1'b1;
				cw.jc      = JC_POST;
				cw.tgt     = ST_IDLE;
			end
			ST_SCAN: begin
				cw.scan = 1'b1;
				cw.jc   = JC_SCAN;
				cw.tgt  = ST_IDLE;
			end
			default: begin
				cw.jc  = JC_POST;
				cw.tgt = ST_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

[sv/ring_entry_offset_locator.sv]
// Top level: ring of entry descriptors with byte offset lookup, microcoded control.
//
// Usage: one input channel (in_valid/in_ready/in_data) and one result channel
// (out_valid/out_ready/out_data), both valid/ready. Every input transaction yields
// exactly one result transaction, in order. mode add writes tag and size at the
// write slot, overwriting the oldest entry once the ring is full; its result is
// all zero. mode find walks the stored entries oldest first and reports the one
// holding byte_offset, or an all-zero result on a miss.
// An add loads the result register from its add step. A find loads it once the
// scan stops, after at most SLOTS entries have been read; the scan reads one
// entry per cycle through the single RAM read port, and the RAM registers its
// read data, so the last entry read is checked after that read.
// One item is in work at a time; in_ready is high only while the sequencer sits in
// its idle step, which it reenters as the result is loaded and which includes
// the time a finished result waits in the output register.
// Reset clears the slot pointers, the full flag, the sequencer and out_valid; the
// entry RAM is not cleared, only written entries are ever scanned.
// A stalled receiver holds out_data; the sequencer stops at its result step until
// the output register frees up.
`timescale 1ns / 1ps

module ring_entry_offset_locator
	import relo_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int RUN_W  = SIZE_W + CNT_W;
	localparam int CMP_W  = (RUN_W + 1 > OFFSET_W) ? RUN_W + 1 : OFFSET_W;
	localparam int ENT_W  = TAG_W + SIZE_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	function automatic logic [SLOT_W-1:0] nxt(logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	step_t               step_q, step_d;
	ctrl_t               cw;
	in_item_t            item_q;
	logic [SLOT_W-1:0]   wr_slot_q, rd_slot_q, idx_q, data_idx_q;
	logic                full_q, rd_vld_q, out_valid_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RUN_W-1:0]    run_q;
	out_item_t           out_data_q, res_d;

	logic                in_acc, out_free, post, scan_go, scan_done, hit_now, ent_ok;
	logic [ENT_W-1:0]    ram_rdata;
	logic [TAG_W-1:0]    ent_tag;
	logic [SIZE_W-1:0]   ent_size;
	logic [CMP_W-1:0]    sum_w, pos_w, diff_w;
	logic [SLOT_W+SLOT_F_W-1:0] slot_ext;
	logic [SLOT_W-1:0]   wr_nxt, rd_nxt;

	assign cw        = ucode(step_q);
	assign in_ready  = cw.accept;
	assign in_acc    = in_valid & cw.accept;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign ent_tag   = ram_rdata[ENT_W-1:SIZE_W];
	assign ent_size  = ram_rdata[SIZE_W-1:0];
	assign ent_ok    = rd_vld_q && (ent_tag != '0) && (ent_size != '0);
	assign sum_w     = CMP_W'(run_q) + CMP_W'(ent_size);
	assign pos_w     = CMP_W'(item_q.byte_offset);
	assign diff_w    = pos_w - CMP_W'(run_q);
	assign hit_now   = ent_ok && (pos_w < sum_w);
	assign scan_done = hit_now || (cnt_q == '0);
	assign scan_go   = cw.scan && !scan_done;
	assign post      = out_free && (cw.ring_wr || (cw.scan && scan_done));
	assign slot_ext  = {{SLOT_F_W{1'b0}}, data_idx_q};

	assign wr_nxt = nxt(wr_slot_q);
	assign rd_nxt = full_q ? nxt(rd_slot_q) : rd_slot_q;

	always_comb begin
		res_d = '0;
		if (cw.scan && hit_now) begin
			res_d.hit           = 1'b1;
			res_d.slot          = slot_ext[SLOT_F_W-1:0];
			res_d.found_tag     = ent_tag;
			res_d.found_size    = ent_size;
			res_d.offset_within = diff_w[SIZE_W-1:0];
		end
	end

	always_comb begin
		step_d = step_q;
		unique case (cw.jc)
			JC_DISPATCH: begin
				if (in_acc) begin
					step_d = (in_data.mode == MODE_FIND) ? ST_SCAN : ST_ADD;
				end
			end
			JC_POST: begin
				if (out_free) begin
					step_d = cw.tgt;
				end
			end
			JC_SCAN: begin
				if (scan_done && out_free) begin
					step_d = cw.tgt;
				end
			end
			default: step_d = ST_IDLE;
		endcase
	end

	relo_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS),
		.AW   (SLOT_W)
	) u_ram (
		.clk  (clk),
		.we   (cw.ring_wr && out_free),
		.waddr(wr_slot_q),
		.wdata({item_q.entry_tag, item_q.entry_size}),
		.re   (scan_go),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			full_q      <= 1'b0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
		end else begin
			step_q <= step_d;
			if (in_acc) begin
				idx_q    <= full_q ? rd_slot_q : '0;
				cnt_q    <= full_q ? CNT_W'(SLOTS) : CNT_W'(wr_slot_q);
				rd_vld_q <= 1'b0;
			end
			if (cw.ring_wr && out_free) begin
				rd_slot_q <= rd_nxt;
				wr_slot_q <= wr_nxt;
				full_q    <= (wr_nxt == rd_nxt);
			end
			if (cw.scan && !(scan_done && !out_free)) begin
				rd_vld_q <= scan_go;
			end
			if (scan_go) begin
				idx_q <= nxt(idx_q);
				cnt_q <= cnt_q - 1'b1;
			end
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
			run_q  <= '0;
		end
		if (scan_go) begin
			data_idx_q <= idx_q;
			if (ent_ok) begin
				run_q <= run_q + RUN_W'(ent_size);
			end
		end
		if (post) begin
			out_data_q <= res_d;
		end
	end

endmodule

[sv/relo_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module relo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/relo_chk.sv]
// Port-level checker for the ring entry offset locator, bound to the top level.
`timescale 1ns / 1ps

module relo_chk
	import relo_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in work");

	// add and miss results carry zeros
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |->
			out_data.slot == '0 && out_data.found_tag == '0 &&
			out_data.found_size == '0 && out_data.offset_within == '0)
		else $error("non-hit result not all zero");

	// a located entry is never empty and the offset lies inside it
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |->
			out_data.found_tag != '0 && out_data.found_size != '0 &&
			out_data.offset_within < out_data.found_size)
		else $error("hit result inconsistent");

endmodule

bind ring_entry_offset_locator relo_chk u_relo_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
